[rtl/contrast_onset_detector_assert.svh]
// Assertion macros for the contrast onset detector checker.
// Needs clk and rst_n in the scope of the using module.
`ifndef CONTRAST_ONSET_DETECTOR_ASSERT_SVH
`define CONTRAST_ONSET_DETECTOR_ASSERT_SVH

// clocked, muted while reset is low
`define COD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked, also checked across reset
`define COD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cod_pkg.sv]
// Shared widths, constants and control types of the contrast onset detector.
// No dependencies; every file but the assertion header imports it.
package cod_pkg;

  localparam int MAX_POINTS = 256;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 8;
  localparam int THR_W    = 6;
  localparam int CNT_W    = 9;
  localparam int SUM_W    = 24;
  localparam int SUMSQ_W  = 40;

  localparam int OPA_W  = 64;
  localparam int OPB_W  = 32;
  localparam int DIG_W  = 16;
  localparam int ACC_W  = 72;
  localparam int PROD_W = OPA_W + DIG_W;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(10);
  localparam logic [INDEX_W-1:0] ONSET_RESET = INDEX_W'(2);
  localparam logic [CNT_W-1:0]   CNT_LIMIT   = CNT_W'(MAX_POINTS);

  typedef struct packed {
    logic en;
    logic first;
    logic sub;
    logic hi;
  } mac_ctl_t;

endpackage

[rtl/cod_in_if.sv]
// Sample channel: valid/ready handshake carrying one trace sample word.
// Depends on cod_pkg.
interface cod_in_if import cod_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] trace_sample;
  logic                last_point;

  modport source (output valid, output trace_sample, output last_point, input ready);
  modport sink   (input valid, input trace_sample, input last_point, output ready);
endinterface

[rtl/cod_out_if.sv]
// Result channel: valid/ready handshake carrying one onset index word.
// Depends on cod_pkg.
interface cod_out_if import cod_pkg::*;;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] injection_index;
  logic               trace_done;

  modport source (output valid, output injection_index, output trace_done, input ready);
  modport sink   (input valid, input injection_index, input trace_done, output ready);
endinterface

[rtl/cod_mac.sv]
// Shared multiply-accumulate unit: 64-bit operand times one 16-bit digit per cycle while ctl.en is set.
// Depends on cod_pkg.
module cod_mac import cod_pkg::*; (
  input  logic             clk,
  input  mac_ctl_t         ctl,
  input  logic [OPA_W-1:0] a_op,
  input  logic [DIG_W-1:0] digit,
  input  logic [ACC_W-1:0] init,
  output logic [ACC_W-1:0] acc_r
);

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  base;
  logic [ACC_W-1:0]  acc_nxt;

  always_comb begin
    prod    = PROD_W'(a_op) * PROD_W'(digit);
    addend  = ctl.hi ? {prod[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} : prod[ACC_W-1:0];
    base    = ctl.first ? init : acc_r;
    acc_nxt = ctl.sub ? (base - addend) : (base + addend);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

[rtl/contrast_onset_detector.sv]
// Top level of the contrast onset detector: sequencer, trace state, output register.
// Depends on cod_pkg, cod_in_if, cod_out_if and cod_mac.
//
//   channel  | dir | word                              | handshake
//   in_ch    | in  | trace_sample[15:0], last_point    | valid/ready
//   out_ch   | out | injection_index[7:0], trace_done  | valid/ready
//   cfg      | in  | cfg_wr_data[5:0] threshold        | cfg_wr_en, no wait
//
// Each sample takes 16 digit passes through the shared 64x16 multiply-accumulate
// unit, then a final state that folds the test into the trace state and registers
// the result, then an idle state that takes the next sample; one sample is in work at a time.
// Synchronous active-low reset; threshold returns to 10, trace state clears.
// A stalled result holds the block in its final cycle; the next sample may
// be taken while a finished result still waits.
module contrast_onset_detector import cod_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  cod_in_if.sink           in_ch,
  cod_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [3:0] ST_LX  = 4'd0;
  localparam logic [3:0] ST_SQ  = 4'd1;
  localparam logic [3:0] ST_NN  = 4'd2;
  localparam logic [3:0] ST_QP  = 4'd3;
  localparam logic [3:0] ST_SS  = 4'd4;
  localparam logic [3:0] ST_NS  = 4'd5;
  localparam logic [3:0] ST_E1  = 4'd6;
  localparam logic [3:0] ST_E2  = 4'd7;
  localparam logic [3:0] ST_E3  = 4'd8;
  localparam logic [3:0] ST_LL  = 4'd9;
  localparam logic [3:0] ST_T2  = 4'd10;
  localparam logic [3:0] ST_A   = 4'd11;
  localparam logic [3:0] ST_CMP = 4'd12;

  localparam logic [1:0] INIT_ZERO  = 2'd0;
  localparam logic [1:0] INIT_NEGS  = 2'd1;
  localparam logic [1:0] INIT_SUMSQ = 2'd2;
  localparam logic [1:0] INIT_KEEP  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       dig_r, dig_nxt;
  logic       wb_r, wb_nxt;
  logic [3:0] wbstep_r, wbstep_nxt;

  logic [THR_W-1:0]    thr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUMSQ_W-1:0]  sumsq_r;
  logic [SAMPLE_W-1:0] prev_r;
  logic [INDEX_W-1:0]  onset_r;

  logic [SAMPLE_W-1:0] x_r;
  logic                last_r;

  logic [INDEX_W-1:0] out_idx_r;
  logic               out_done_r;
  logic               out_valid_r, out_valid_nxt;

  logic [23:0] l_r;
  logic        lpos_r;
  logic [31:0] sq_r;
  logic [15:0] nn_r;
  logic [39:0] qp_r;
  logic [47:0] ss_r;
  logic [33:0] ns2_r;
  logic [57:0] e_r;
  logic [47:0] ll_r;
  logic [11:0] t2_r;

  logic [OPA_W-1:0] a_op;
  logic [OPB_W-1:0] b_op;
  logic             two_dig;
  logic [1:0]       init_sel;
  logic             op_sub;
  logic [ACC_W-1:0] init_val;
  logic [ACC_W-1:0] acc_r;
  mac_ctl_t         mac_ctl;

  logic [INDEX_W-1:0] n_val;
  logic [INDEX_W-1:0] p_val;
  logic [SUM_W-1:0]   s_prime;
  logic               in_acc;
  logic               out_free;
  logic               fin_go;
  logic               step_end;
  logic               in_range;
  logic               hit;
  logic [INDEX_W-1:0] onset_upd;

  assign n_val    = cnt_r[INDEX_W-1:0];
  assign p_val    = n_val - INDEX_W'(1);
  assign s_prime  = sum_r - SUM_W'(prev_r);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign fin_go   = (state_r == S_FIN) && out_free;
  assign step_end = two_dig ? dig_r : 1'b1;
  assign in_range = cnt_r < CNT_LIMIT;
  assign hit      = lpos_r && !acc_r[ACC_W-1] && (acc_r != '0);

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.injection_index = out_idx_r;
  assign out_ch.trace_done      = out_done_r;

  always_comb begin
    a_op     = '0;
    b_op     = '0;
    two_dig  = 1'b0;
    init_sel = INIT_ZERO;
    op_sub   = 1'b0;
    case (step_r)
      ST_LX: begin
        a_op     = OPA_W'(x_r);
        b_op     = OPB_W'(n_val);
        init_sel = INIT_NEGS;
      end
      ST_SQ: begin
        a_op = OPA_W'(x_r);
        b_op = OPB_W'(x_r);
      end
      ST_NN: begin
        a_op = OPA_W'(n_val);
        b_op = OPB_W'(n_val);
      end
      ST_QP: begin
        a_op     = OPA_W'(prev_r);
        b_op     = OPB_W'(prev_r);
        init_sel = INIT_SUMSQ;
        op_sub   = 1'b1;
      end
      ST_SS: begin
        a_op    = OPA_W'(sum_r);
        b_op    = OPB_W'(sum_r);
        two_dig = 1'b1;
      end
      ST_NS: begin
        a_op = OPA_W'(sum_r);
        b_op = OPB_W'({n_val, 1'b0});
      end
      ST_E1: begin
        a_op = OPA_W'(qp_r);
        b_op = OPB_W'(nn_r);
      end
      ST_E2: begin
        a_op     = OPA_W'(ss_r);
        b_op     = OPB_W'(p_val);
        init_sel = INIT_KEEP;
      end
      ST_E3: begin
        a_op     = OPA_W'(ns2_r);
        b_op     = OPB_W'(s_prime);
        two_dig  = 1'b1;
        init_sel = INIT_KEEP;
        op_sub   = 1'b1;
      end
      ST_LL: begin
        a_op    = OPA_W'(l_r);
        b_op    = OPB_W'(l_r);
        two_dig = 1'b1;
      end
      ST_T2: begin
        a_op = OPA_W'(thr_r);
        b_op = OPB_W'(thr_r);
      end
      ST_A: begin
        a_op = OPA_W'(ll_r);
        b_op = OPB_W'({p_val, 4'b0000});
      end
      ST_CMP: begin
        a_op     = OPA_W'(e_r);
        b_op     = OPB_W'(t2_r);
        init_sel = INIT_KEEP;
        op_sub   = 1'b1;
      end
      default: begin
        a_op = '0;
      end
    endcase
  end

  always_comb begin
    case (init_sel)
      INIT_NEGS:  init_val = ACC_W'(0) - ACC_W'(sum_r);
      INIT_SUMSQ: init_val = ACC_W'(sumsq_r);
      default:    init_val = '0;
    endcase
    mac_ctl.en    = (state_r == S_RUN);
    mac_ctl.first = (init_sel != INIT_KEEP) && !dig_r;
    mac_ctl.sub   = op_sub;
    mac_ctl.hi    = dig_r;
  end

  cod_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .a_op  (a_op),
    .digit (dig_r ? b_op[OPB_W-1:DIG_W] : b_op[DIG_W-1:0]),
    .init  (init_val),
    .acc_r (acc_r)
  );

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    dig_nxt    = dig_r;
    wb_nxt     = 1'b0;
    wbstep_nxt = wbstep_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
          step_nxt  = ST_LX;
          dig_nxt   = 1'b0;
        end
      end
      S_RUN: begin
        if (step_end) begin
          wb_nxt     = 1'b1;
          wbstep_nxt = step_r;
          dig_nxt    = 1'b0;
          if (step_r == ST_CMP) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end else begin
          dig_nxt = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign onset_upd = (in_range && (cnt_r >= CNT_W'(2)) && hit) ?
                     (n_val - INDEX_W'(1)) : onset_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_LX;
      dig_r       <= 1'b0;
      wb_r        <= 1'b0;
      wbstep_r    <= ST_LX;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      prev_r      <= '0;
      onset_r     <= ONSET_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dig_r       <= dig_nxt;
      wb_r        <= wb_nxt;
      wbstep_r    <= wbstep_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (fin_go) begin
        if (last_r) begin
          cnt_r   <= '0;
          sum_r   <= '0;
          sumsq_r <= '0;
          prev_r  <= '0;
          onset_r <= ONSET_RESET;
        end else if (in_range) begin
          cnt_r   <= cnt_r + CNT_W'(1);
          sum_r   <= sum_r + SUM_W'(x_r);
          sumsq_r <= sumsq_r + SUMSQ_W'(sq_r);
          prev_r  <= x_r;
          onset_r <= onset_upd;
        end
      end
    end
  end

  // capture the word and the result, and hold the results of the steps that later steps read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= in_ch.trace_sample;
      last_r <= in_ch.last_point;
    end
    if (fin_go) begin
      out_idx_r  <= onset_upd;
      out_done_r <= last_r;
    end
    if (wb_r) begin
      case (wbstep_r)
        ST_LX: begin
          l_r    <= acc_r[23:0];
          lpos_r <= !acc_r[ACC_W-1] && (acc_r != '0);
        end
        ST_SQ:   sq_r  <= acc_r[31:0];
        ST_NN:   nn_r  <= acc_r[15:0];
        ST_QP:   qp_r  <= acc_r[39:0];
        ST_SS:   ss_r  <= acc_r[47:0];
        ST_NS:   ns2_r <= acc_r[33:0];
        ST_E3:   e_r   <= acc_r[57:0];
        ST_LL:   ll_r  <= acc_r[47:0];
        ST_T2:   t2_r  <= acc_r[11:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/cod_checker.sv]
// Port-level checker for the contrast onset detector, bound to the top level.
// Depends on cod_pkg, contrast_onset_detector_assert.svh and the top level's ports.
`include "contrast_onset_detector_assert.svh"

module cod_checker import cod_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] out_index,
  input logic               out_done
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `COD_ASSERT_RST(a_reset_clean, !rst_n |=> (!out_valid && in_ready), "reset leaves state busy")
  `COD_ASSERT(a_busy_after_accept, in_acc |=> !in_ready, "second word taken while busy")
  `COD_ASSERT(a_result_while_busy, $rose(out_valid) |-> !$past(in_ready), "result without work")
  `COD_ASSERT(a_out_hold, out_stall |=> out_valid, "result dropped while stalled")
  `COD_ASSERT(a_out_stable, out_stall |=> ($stable(out_index) && $stable(out_done)), "result changed while stalled")

endmodule

bind contrast_onset_detector cod_checker u_cod_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.injection_index),
  .out_done  (out_ch.trace_done)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for contrast_onset_detector: directed trace table, then random traces.
// Predicts each onset word from its own copy of the trace state, unless a typed table row
// gives it; needs cod_pkg and the cod_in_if / cod_out_if channel interfaces.
module tb;
  import cod_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int N_DIRECTED    = 20;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               done;
  } onset_word_t;

  typedef struct packed {
    logic                wr;
    logic [THR_W-1:0]    thr;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                typed;
    logic [INDEX_W-1:0]  index;
  } trace_row_t;

  typedef enum {SHAPE_BOLUS, SHAPE_NOISE, SHAPE_FLAT, SHAPE_RAIL} trace_shape_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  cod_in_if  in_ch();
  cod_out_if out_ch();

  contrast_onset_detector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [THR_W-1:0]   thr_quarters;
  logic [CNT_W-1:0]   trace_cnt;
  logic [SUM_W-1:0]   trace_sum;
  logic [SUMSQ_W-1:0] trace_sumsq;
  logic [SAMPLE_W-1:0] trace_prev;
  logic [INDEX_W-1:0] trace_onset;

  onset_word_t pending_onsets[$];
  onset_word_t oldest_onset;

  int cycle_count;
  int mismatches;
  int results_seen;
  int samples_sent;
  int traces_sent;
  int long_traces;
  int thr_writes;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_request;
  bit rx_held;

  trace_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 6'd0,  16'd0,     1'b1, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd65535, 1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd65535, 1'b1, 1'b1, ONSET_RESET},
    '{1'b1, 6'd0,  16'd100,   1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd100,   1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd100,   1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd101,   1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd0,     1'b1, 1'b0, 8'd0},
    '{1'b1, 6'd63, 16'd65535, 1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd0,     1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd65535, 1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd0,     1'b0, 1'b0, 8'd0},
    '{1'b1, 6'd10, 16'd65535, 1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd65535, 1'b1, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd1000,  1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd1000,  1'b0, 1'b1, ONSET_RESET},
    '{1'b0, 6'd0,  16'd1000,  1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd1000,  1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd60000, 1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd0,  16'd0,     1'b1, 1'b0, 8'd0}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic void clear_trace_state();
    trace_cnt   = '0;
    trace_sum   = '0;
    trace_sumsq = '0;
    trace_prev  = '0;
    trace_onset = ONSET_RESET;
  endfunction

  // exact integer form of x > mean + (thr/4) * sd, no root taken
  function automatic onset_word_t predict_onset(input logic [SAMPLE_W-1:0] x,
                                                input logic last);
    logic [127:0] n, p, s, sp, qp, t2, e, l, a, nx;
    onset_word_t w;
    if (trace_cnt < CNT_LIMIT) begin
      n  = 128'(trace_cnt);
      p  = n - 128'd1;
      s  = 128'(trace_sum);
      sp = s - 128'(trace_prev);
      qp = 128'(trace_sumsq) - 128'(trace_prev) * 128'(trace_prev);
      t2 = 128'(thr_quarters) * 128'(thr_quarters);
      nx = n * 128'(x);
      l  = nx - s;
      e  = n * n * qp + p * s * s - 128'd2 * n * s * sp;
      a  = 128'd16 * l * l * p;
      if (trace_cnt >= CNT_W'(2) && nx > s && a > t2 * e)
        trace_onset = INDEX_W'(trace_cnt - CNT_W'(1));
      trace_sum   = trace_sum + SUM_W'(x);
      trace_sumsq = trace_sumsq + SUMSQ_W'(x) * SUMSQ_W'(x);
      trace_prev  = x;
      trace_cnt   = trace_cnt + CNT_W'(1);
    end
    w.index = trace_onset;
    w.done  = last;
    if (last)
      clear_trace_state();
    return w;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic last,
                             input logic typed, input logic [INDEX_W-1:0] typed_index);
    onset_word_t w;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.trace_sample <= x;
    in_ch.last_point   <= last;
    do @(posedge clk); while (!in_ch.ready);
    w = predict_onset(x, last);
    if (typed)
      w.index = typed_index;
    pending_onsets.push_back(w);
    samples_sent++;
    if (last)
      traces_sent++;
  endtask

  // drain the block before touching the threshold
  task automatic write_threshold(input logic [THR_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_onsets.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    thr_quarters = value;
    thr_writes++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_onsets.size() == 0) begin
        report($sformatf("unexpected word index=%0d done=%0b",
                         out_ch.injection_index, out_ch.trace_done));
      end else begin
        oldest_onset = pending_onsets.pop_front();
        if (out_ch.injection_index !== oldest_onset.index)
          report($sformatf("injection_index got %0d want %0d",
                           out_ch.injection_index, oldest_onset.index));
        if (out_ch.trace_done !== oldest_onset.done)
          report($sformatf("trace_done got %0b want %0b",
                           out_ch.trace_done, oldest_onset.done));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_onsets.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rx_held      = 1'b1;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
        if (stall_left == 0)
          rx_held = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int random_items;
    int trace_no;
    int len;
    int k;
    int v;
    int base;
    int noise_amp;
    int jump;
    int onset_at;
    int r;
    trace_shape_t shape;
    logic [SAMPLE_W-1:0] x;
    logic [THR_W-1:0] thr;

    cycle_count  = 0;
    mismatches   = 0;
    results_seen = 0;
    samples_sent = 0;
    traces_sent  = 0;
    long_traces  = 0;
    thr_writes   = 0;
    hold_request = 1'b0;
    rx_held      = 1'b0;
    tx_idle_pct  = 11;
    rx_idle_pct  = 47;
    thr_quarters = THR_RESET;
    clear_trace_state();

    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.trace_sample <= '0;
    in_ch.last_point   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr)
        write_threshold(directed_rows[i].thr);
      send_sample(directed_rows[i].sample, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].index);
    end

    random_items = 0;
    trace_no     = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 11;
        rx_idle_pct = 47;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 47;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (!rx_held && !hold_request && $urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0:       thr = '0;
          1:       thr = '1;
          default: thr = THR_W'($urandom_range(0, 63));
        endcase
        write_threshold(thr);
      end

      if (trace_no == 4 || trace_no == 30) begin
        len = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 34);
        long_traces++;
      end else if ($urandom_range(5) == 0) begin
        len = $urandom_range(1, 3);
      end else begin
        len = $urandom_range(4, 40);
      end

      r = $urandom_range(9);
      shape = (r < 7) ? SHAPE_BOLUS : (r == 7) ? SHAPE_NOISE :
              (r == 8) ? SHAPE_FLAT : SHAPE_RAIL;
      base      = $urandom_range(0, 40000);
      noise_amp = ($urandom_range(1) == 0) ? $urandom_range(0, 50) : $urandom_range(0, 3000);
      jump      = $urandom_range(0, 30000);
      onset_at  = $urandom_range(2, (len > 2) ? len : 2);

      for (k = 0; k < len; k++) begin
        if (random_items == 200 || random_items == 800)
          hold_request = 1'b1;
        if (k > 0 && !rx_held && !hold_request && $urandom_range(59) == 0)
          write_threshold(THR_W'($urandom_range(0, 63)));
        case (shape)
          SHAPE_BOLUS: begin
            v = base + $urandom_range(0, noise_amp);
            if (k >= onset_at)
              v = v + jump;
            x = (v > 65535) ? 16'hFFFF : SAMPLE_W'(v);
          end
          SHAPE_NOISE: x = SAMPLE_W'($urandom_range(0, 65535));
          SHAPE_FLAT:  x = SAMPLE_W'(base);
          default:     x = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
        endcase
        send_sample(x, (k == len - 1), 1'b0, '0);
        if (k < MAX_POINTS)
          random_items++;
      end
      trace_no++;
    end

    in_ch.valid <= 1'b0;
    while (pending_onsets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples in %0d traces, %0d of them past the %0d point limit",
             samples_sent, traces_sent, long_traces, MAX_POINTS);
    $display("%0d onset words checked, %0d threshold writes, %0d mismatches",
             results_seen, thr_writes, mismatches);
    if (mismatches == 0 && pending_onsets.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
